// ===== hdl/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, prop)
`endif
`endif

// ===== hdl/dtt_pkg.sv =====
package dtt_pkg;

  localparam logic [2:0] CMD_ARM = 3'd0;
  localparam logic [2:0] CMD_CANCEL = 3'd1;
  localparam logic [2:0] CMD_REFRESH = 3'd2;
  localparam logic [2:0] CMD_REPERIOD = 3'd3;
  localparam logic [2:0] CMD_EXPIRE = 3'd4;
  localparam logic [2:0] CMD_QUERY = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [31:0] WINDOW_RESET = 32'd3600000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  slot;
    logic [31:0] period_ms;
    logic        recurring;
    logic        restart_now;
    logic [63:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  out_slot;
    logic        fired;
    logic [63:0] wait_ms;
    logic        front_notice;
    logic        last;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, clear scan registers
    logic scan;      // examine slot at scan index
    logic scan_rst;  // restart scan index
    logic commit;    // apply single-slot command
    logic fire;      // retire best candidate
    logic roll_eval; // decide rollover and due set
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic any_armed;
    logic best_valid;
  } sts_t;

endpackage

// ===== hdl/dtt_ctrl.sv =====
module dtt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic [2:0]    cmd_i,
  input  dtt_pkg::sts_t sts_i,
  output dtt_pkg::ctl_t ctl_o,
  output logic          busy,
  output logic          emit_o,
  output logic          emit_last_o,
  output logic          emit_fire_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DONE, S_EXSCAN, S_EXNEXT
  } state_e;

  state_e state_q;
  logic   is_exp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      is_exp_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: if (start) begin
          state_q  <= S_SCAN;
          is_exp_q <= (cmd_i == dtt_pkg::CMD_EXPIRE);
        end
        S_SCAN: if (sts_i.scan_done) state_q <= S_DONE;
        S_DONE: begin
          if (is_exp_q && sts_i.any_armed) state_q <= S_EXSCAN;
          else state_q <= S_IDLE;
        end
        S_EXSCAN: if (sts_i.scan_done) state_q <= S_EXNEXT;
        S_EXNEXT: begin
          if (sts_i.best_valid) state_q <= S_EXSCAN;
          else state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    ctl_o = '0;
    emit_o = 1'b0;
    emit_last_o = 1'b0;
    emit_fire_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        ctl_o.load = start;
        ctl_o.scan_rst = start;
      end
      S_SCAN: ctl_o.scan = 1'b1;
      S_DONE: begin
        if (is_exp_q && sts_i.any_armed) begin
          ctl_o.roll_eval = 1'b1;
          ctl_o.scan_rst = 1'b1;
        end else begin
          ctl_o.commit = 1'b1;
          emit_o = 1'b1;
          emit_last_o = 1'b1;
        end
      end
      S_EXSCAN: ctl_o.scan = 1'b1;
      S_EXNEXT: begin
        ctl_o.fire = 1'b1;
        ctl_o.scan_rst = 1'b1;
        // a found candidate is held pending and reported at the next fire; lastness is resolved by lookahead
        emit_o = sts_i.best_valid;
        emit_fire_o = sts_i.best_valid;
      end
      default: ;
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ===== hdl/dtt_datapath.sv =====
module dtt_datapath #(
  parameter int SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dtt_pkg::ctl_t ctl_i,
  input  dtt_pkg::req_t req_i,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_data_i,
  input  logic          emit_i,
  input  logic          emit_last_i,
  input  logic          emit_fire_i,
  output dtt_pkg::sts_t sts_o,
  output logic          rsp_valid_o,
  output dtt_pkg::rsp_t rsp_o
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  logic [SLOTS-1:0] armed_q, due_q;
  logic [SLOTS-1:0] rep_q;
  logic [31:0]      per_q [SLOTS];
  logic [63:0]      dl_q  [SLOTS];
  logic [63:0]      prev_q;
  logic             notice_q;
  logic [31:0]      win_q;
  dtt_pkg::req_t    req_q;

  logic [CW-1:0] idx_q;
  logic [IW-1:0] idx;
  // scan results
  logic          best_v_q;
  logic [IW-1:0] best_q;
  logic [63:0]   best_dl_q;
  logic          free_v_q;
  logic [IW-1:0] free_q;
  logic          tgt_before_q; // armed slot ahead of the target
  logic          any_q;
  // pending fired result awaiting lastness
  logic          pend_q;
  logic [IW-1:0] pend_slot_q;

  logic          in_range;
  logic [IW-1:0] tgt;
  logic [63:0]   tgt_dl_new;
  logic [63:0]   dl_i;
  logic          cand;
  logic          ahead;
  logic          roll;
  logic          commit;
  logic          unchanged;  // keep-start re-period to the stored period
  logic          notice_set;
  logic          rsp_valid_d;
  dtt_pkg::rsp_t rsp_d;

  assign idx = idx_q[IW-1:0];
  assign in_range = (32'(req_q.slot) < 32'(SLOTS));
  assign tgt = (req_q.cmd == dtt_pkg::CMD_ARM) ? free_q : IW'(req_q.slot);
  assign commit = ctl_i.commit && emit_i && emit_last_i;
  assign unchanged = (req_q.cmd == dtt_pkg::CMD_REPERIOD) &&
                     (req_q.period_ms == per_q[tgt]) && !req_q.restart_now;

  // new deadline of the target for arm / re-period, known before the scan
  always_comb begin
    tgt_dl_new = req_q.now_ms + 64'(req_q.period_ms);
    if (req_q.cmd == dtt_pkg::CMD_REPERIOD && !req_q.restart_now)
      tgt_dl_new = dl_q[tgt] - 64'(per_q[tgt]) + 64'(req_q.period_ms);
  end

  assign dl_i = dl_q[idx];
  assign cand = ctl_i.roll_eval ? 1'b0 : (ctl_i.scan && (req_q.cmd == dtt_pkg::CMD_EXPIRE &&
                due_q[idx] || req_q.cmd != dtt_pkg::CMD_EXPIRE && armed_q[idx]));

  // armed slot idx comes before target with its new deadline; for arm the
  // free slot is still ahead of the scan until found, so ties go to idx
  always_comb begin
    if (dl_i != tgt_dl_new) ahead = dl_i < tgt_dl_new;
    else if (req_q.cmd == dtt_pkg::CMD_ARM && !free_v_q) ahead = 1'b1;
    else ahead = idx < tgt;
  end

  assign sts_o.scan_done = (idx_q == CW'(SLOTS - 1)) && ctl_i.scan;
  assign sts_o.any_armed = any_q;
  assign sts_o.best_valid = best_v_q;

  assign roll = (req_q.now_ms < prev_q) &&
                (req_q.now_ms < (prev_q - 64'(win_q)));

  // result of this cycle
  always_comb begin
    rsp_valid_d = 1'b0;
    notice_set = 1'b0;
    rsp_d = '{status: dtt_pkg::ST_OK, out_slot: 4'd0, fired: 1'b0,
              wait_ms: '0, front_notice: 1'b0, last: 1'b1};
    if (ctl_i.fire) begin
      if (pend_q) begin
        rsp_valid_d = 1'b1;
        rsp_d.out_slot = 4'(pend_slot_q);
        rsp_d.fired = 1'b1;
        rsp_d.last = !best_v_q;
      end else if (!best_v_q) begin
        rsp_valid_d = 1'b1;
      end
    end
    if (commit) begin
      rsp_valid_d = 1'b1;
      unique case (req_q.cmd) inside
        dtt_pkg::CMD_ARM: begin
          if (!free_v_q) rsp_d.status = dtt_pkg::ST_FULL;
          else begin
            rsp_d.out_slot = 4'(free_q);
            notice_set = !tgt_before_q && !notice_q;
          end
        end
        dtt_pkg::CMD_CANCEL, dtt_pkg::CMD_REFRESH, dtt_pkg::CMD_REPERIOD: begin
          if (!in_range) rsp_d.status = dtt_pkg::ST_REFUSED;
          else if (unchanged) ;
          else if (!armed_q[tgt]) rsp_d.status = dtt_pkg::ST_REFUSED;
          else if (req_q.cmd == dtt_pkg::CMD_REPERIOD)
            notice_set = !tgt_before_q && !notice_q;
        end
        dtt_pkg::CMD_QUERY: begin
          if (!best_v_q) rsp_d.wait_ms = '1;
          else if (req_q.now_ms < best_dl_q)
            rsp_d.wait_ms = best_dl_q - req_q.now_ms;
        end
        dtt_pkg::CMD_EXPIRE: ;
        default: rsp_d.status = dtt_pkg::ST_REFUSED;
      endcase
      rsp_d.front_notice = notice_set;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q  <= '0;
      prev_q   <= '0;
      notice_q <= 1'b0;
      win_q    <= dtt_pkg::WINDOW_RESET;
      idx_q    <= '0;
      pend_q   <= 1'b0;
      best_v_q <= 1'b0;
      rsp_valid_o <= 1'b0;
    end else begin
      rsp_valid_o <= rsp_valid_d;
      if (rsp_valid_d) rsp_o <= rsp_d;
      if (cfg_we_i) win_q <= cfg_data_i;
      if (ctl_i.load) begin
        req_q <= req_i;
        best_v_q <= 1'b0;
        free_v_q <= 1'b0;
        free_q <= '0;
        tgt_before_q <= 1'b0;
        any_q <= 1'b0;
        pend_q <= 1'b0;
      end
      if (ctl_i.scan_rst) begin
        idx_q <= '0;
      end else if (ctl_i.scan) begin
        idx_q <= idx_q + 1'b1;
      end
      if (ctl_i.scan) begin
        if (armed_q[idx]) any_q <= 1'b1;
        if (!armed_q[idx] && !free_v_q) begin
          free_v_q <= 1'b1;
          free_q <= idx;
        end
        // the target itself never counts against its own notice
        if (armed_q[idx] && ahead &&
            !(req_q.cmd != dtt_pkg::CMD_ARM && idx == tgt))
          tgt_before_q <= 1'b1;
        if (cand && (!best_v_q || dl_i < best_dl_q)) begin
          best_v_q <= 1'b1;
          best_q <= idx;
          best_dl_q <= dl_i;
        end
      end
      if (ctl_i.roll_eval) begin
        prev_q <= req_q.now_ms;
        for (int s = 0; s < SLOTS; s++)
          due_q[s] <= armed_q[s] && (roll || dl_q[s] <= req_q.now_ms);
        best_v_q <= 1'b0;
      end
      if (ctl_i.fire) begin
        best_v_q <= 1'b0;
        if (emit_fire_i) begin
          pend_q <= 1'b1;
          pend_slot_q <= best_q;
          due_q[best_q] <= 1'b0;
          if (rep_q[best_q]) dl_q[best_q] <= req_q.now_ms + 64'(per_q[best_q]);
          else armed_q[best_q] <= 1'b0;
        end
      end
      if (commit) begin
        if (notice_set) notice_q <= 1'b1;
        unique case (req_q.cmd) inside
          dtt_pkg::CMD_ARM: begin
            if (free_v_q) begin
              armed_q[free_q] <= 1'b1;
              rep_q[free_q] <= req_q.recurring;
              per_q[free_q] <= req_q.period_ms;
              dl_q[free_q] <= tgt_dl_new;
            end
          end
          dtt_pkg::CMD_CANCEL, dtt_pkg::CMD_REFRESH, dtt_pkg::CMD_REPERIOD: begin
            if (in_range && !unchanged && armed_q[tgt]) begin
              if (req_q.cmd == dtt_pkg::CMD_CANCEL) armed_q[tgt] <= 1'b0;
              else if (req_q.cmd == dtt_pkg::CMD_REFRESH)
                dl_q[tgt] <= req_q.now_ms + 64'(per_q[tgt]);
              else begin
                per_q[tgt] <= req_q.period_ms;
                dl_q[tgt] <= tgt_dl_new;
              end
            end
          end
          dtt_pkg::CMD_QUERY: notice_q <= 1'b0;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hdl/deadline_timer_table.sv =====
// deadline timer table: a command is taken when start is high and busy low;
// results appear one per cycle-strobe on rsp_valid_o and cannot be stalled.
// every command scans all SLOTS slots once; an expire with a timer armed then
// rescans the due set once per fired timer and once more to find none. the
// scan over the slot registers sets the time taken. the last result of each
// command carries last.
`include "assert_macros.svh"
module deadline_timer_table #(
  parameter int SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  dtt_pkg::req_t req_i,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_data_i,
  output logic          rsp_valid_o,
  output dtt_pkg::rsp_t rsp_o
);

  dtt_pkg::ctl_t ctl;
  dtt_pkg::sts_t sts;
  logic emit, emit_last, emit_fire;

  // sequencer
  dtt_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .cmd_i(req_i.cmd), .sts_i(sts), .ctl_o(ctl),
    .busy, .emit_o(emit), .emit_last_o(emit_last), .emit_fire_o(emit_fire)
  );

  // slot table and scan logic
  dtt_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .req_i, .cfg_we_i, .cfg_data_i,
    .emit_i(emit), .emit_last_i(emit_last), .emit_fire_i(emit_fire),
    .sts_o(sts), .rsp_valid_o, .rsp_o
  );

  // a transaction is never accepted while busy
  `ASSERT_NEVER(a_load_idle, clk_i, rst_ni, ctl.load && busy)
  // a fired result always reports ok
  `ASSERT_IMPL(a_fired_ok, clk_i, rst_ni, rsp_valid_o && rsp_o.fired |-> rsp_o.status == dtt_pkg::ST_OK)

endmodule

// ===== tb/dtt_checker.sv =====
module dtt_checker #(
  parameter int SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  dtt_pkg::req_t req_i,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_data_i,
  input  logic          rsp_valid_i,
  input  dtt_pkg::rsp_t rsp_i,
  output int            errors_o,
  output int            pending_o
);

  logic          tm_armed[SLOTS];
  logic          tm_repeats[SLOTS];
  logic [31:0]   tm_period[SLOTS];
  logic [63:0]   tm_deadline[SLOTS];
  logic [63:0]   last_expire_ms;
  logic          notice_out;
  logic [31:0]   window_ms;
  dtt_pkg::rsp_t timer_rsp_q[$];

  initial errors_o = 0;
  initial pending_o = 0;

  // deadline order, ties broken by slot number
  function automatic logic sooner(int a, int b);
    if (tm_deadline[a] != tm_deadline[b]) return tm_deadline[a] < tm_deadline[b];
    return a < b;
  endfunction

  function automatic logic claim_front(int s);
    for (int t = 0; t < SLOTS; t++)
      if (t != s && tm_armed[t] && sooner(t, s)) return 1'b0;
    if (notice_out) return 1'b0;
    notice_out = 1'b1;
    return 1'b1;
  endfunction

  function automatic dtt_pkg::rsp_t mk(int st, int sl, int f, logic [63:0] w,
                                       int nt, int l);
    dtt_pkg::rsp_t r;
    r.status = 2'(st);
    r.out_slot = 4'(sl);
    r.fired = 1'(f);
    r.wait_ms = w;
    r.front_notice = 1'(nt);
    r.last = 1'(l);
    return r;
  endfunction

  function automatic void queue_rsp(dtt_pkg::rsp_t r);
    timer_rsp_q.insert(timer_rsp_q.size(), r);
  endfunction

  task automatic predict(dtt_pkg::req_t r);
    int s;
    int best;
    int n;
    logic any;
    logic roll;
    logic nt;
    logic [63:0] w;
    logic [63:0] t0;
    logic due[SLOTS];
    int order[SLOTS];
    case (r.cmd) inside
      dtt_pkg::CMD_ARM: begin
        s = SLOTS;
        for (int i = SLOTS - 1; i >= 0; i--) if (!tm_armed[i]) s = i;
        if (s == SLOTS) begin
          queue_rsp(mk(dtt_pkg::ST_FULL, 0, 0, 0, 0, 1));
        end else begin
          tm_armed[s] = 1'b1;
          tm_repeats[s] = r.recurring;
          tm_period[s] = r.period_ms;
          tm_deadline[s] = r.now_ms + 64'(r.period_ms);
          nt = claim_front(s);
          queue_rsp(mk(dtt_pkg::ST_OK, s, 0, 0, nt, 1));
        end
      end
      dtt_pkg::CMD_CANCEL, dtt_pkg::CMD_REFRESH, dtt_pkg::CMD_REPERIOD: begin
        s = r.slot;
        if (s >= SLOTS) begin
          queue_rsp(mk(dtt_pkg::ST_REFUSED, 0, 0, 0, 0, 1));
        end else if (r.cmd == dtt_pkg::CMD_REPERIOD && r.period_ms == tm_period[s] &&
                     !r.restart_now) begin
          queue_rsp(mk(dtt_pkg::ST_OK, 0, 0, 0, 0, 1));
        end else if (!tm_armed[s]) begin
          queue_rsp(mk(dtt_pkg::ST_REFUSED, 0, 0, 0, 0, 1));
        end else if (r.cmd == dtt_pkg::CMD_CANCEL) begin
          tm_armed[s] = 1'b0;
          queue_rsp(mk(dtt_pkg::ST_OK, 0, 0, 0, 0, 1));
        end else if (r.cmd == dtt_pkg::CMD_REFRESH) begin
          tm_deadline[s] = r.now_ms + 64'(tm_period[s]);
          queue_rsp(mk(dtt_pkg::ST_OK, 0, 0, 0, 0, 1));
        end else begin
          t0 = r.restart_now ? r.now_ms : tm_deadline[s] - 64'(tm_period[s]);
          tm_period[s] = r.period_ms;
          tm_deadline[s] = t0 + 64'(r.period_ms);
          nt = claim_front(s);
          queue_rsp(mk(dtt_pkg::ST_OK, 0, 0, 0, nt, 1));
        end
      end
      dtt_pkg::CMD_QUERY: begin
        best = SLOTS;
        w = '1;
        notice_out = 1'b0;
        for (int i = 0; i < SLOTS; i++)
          if (tm_armed[i] && (best == SLOTS || sooner(i, best))) best = i;
        if (best < SLOTS)
          w = (r.now_ms >= tm_deadline[best]) ? 64'd0 : tm_deadline[best] - r.now_ms;
        queue_rsp(mk(dtt_pkg::ST_OK, 0, 0, w, 0, 1));
      end
      dtt_pkg::CMD_EXPIRE: begin
        any = 1'b0;
        n = 0;
        for (int i = 0; i < SLOTS; i++) any |= tm_armed[i];
        if (!any) begin
          queue_rsp(mk(dtt_pkg::ST_OK, 0, 0, 0, 0, 1));
        end else begin
          // rollover uses a wrapping subtraction of the window
          roll = r.now_ms < last_expire_ms &&
                 r.now_ms < last_expire_ms - 64'(window_ms);
          last_expire_ms = r.now_ms;
          for (int i = 0; i < SLOTS; i++)
            due[i] = tm_armed[i] && (roll || tm_deadline[i] <= r.now_ms);
          forever begin
            best = SLOTS;
            for (int i = 0; i < SLOTS; i++)
              if (due[i] && (best == SLOTS || sooner(i, best))) best = i;
            if (best == SLOTS) break;
            due[best] = 1'b0;
            order[n] = best;
            n++;
          end
          if (n == 0) queue_rsp(mk(dtt_pkg::ST_OK, 0, 0, 0, 0, 1));
          for (int k = 0; k < n; k++) begin
            s = order[k];
            if (tm_repeats[s]) tm_deadline[s] = r.now_ms + 64'(tm_period[s]);
            else tm_armed[s] = 1'b0;
            queue_rsp(mk(dtt_pkg::ST_OK, s, 1, 0, 0, int'(k == n - 1)));
          end
        end
      end
      default: begin
        queue_rsp(mk(dtt_pkg::ST_REFUSED, 0, 0, 0, 0, 1));
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dtt_pkg::rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        tm_armed[i] = 1'b0;
        tm_repeats[i] = 1'b0;
        tm_period[i] = '0;
        tm_deadline[i] = '0;
      end
      last_expire_ms = '0;
      notice_out = 1'b0;
      window_ms = dtt_pkg::WINDOW_RESET;
      timer_rsp_q.delete();
    end else begin
      if (rsp_valid_i) begin
        if (timer_rsp_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("unexpected result %p", rsp_i);
        end else begin
          want = timer_rsp_q.pop_front();
          if (rsp_i.status !== want.status || rsp_i.out_slot !== want.out_slot ||
              rsp_i.fired !== want.fired || rsp_i.wait_ms !== want.wait_ms ||
              rsp_i.front_notice !== want.front_notice || rsp_i.last !== want.last) begin
            errors_o++;
            if (errors_o <= 10) $display("mismatch: expected %p got %p", want, rsp_i);
          end
        end
      end
      if (cfg_we_i) window_ms = cfg_data_i;
      if (start_i && !busy_i) predict(req_i);
    end
    pending_o = timer_rsp_q.size();
  end

endmodule

// ===== tb/tb_deadline_timer_table.sv =====
module tb_deadline_timer_table;

  // codes the block must refuse
  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;
  localparam int LIMIT = 900000;
  localparam int DRAIN = 400;  // longer than a full expire scan

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  dtt_pkg::req_t req = '0;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;
  logic rsp_valid;
  dtt_pkg::rsp_t rsp;
  int errors;
  int pending;
  int cycles = 0;
  int sent = 0;
  logic calm = 1'b0;          // no idling in the last part of the run
  logic [63:0] clock_ms = 64'd1000;
  bit used_period[logic [31:0]];

  always #2 clk_i = ~clk_i;

  deadline_timer_table #(.SLOTS(16)) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .rsp_valid_o(rsp_valid),
    .rsp_o      (rsp)
  );

  dtt_checker #(.SLOTS(16)) i_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_i     (busy),
    .req_i      (req),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .rsp_valid_i(rsp_valid),
    .rsp_i      (rsp),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // start stays high across back-to-back transactions
  task automatic send(logic [2:0] c, logic [3:0] sl, logic [31:0] p, logic rc, logic fn,
                      logic [63:0] now);
    start <= 1'b1;
    req <= '{cmd: c, slot: sl, period_ms: p, recurring: rc, restart_now: fn, now_ms: now};
    if (c == dtt_pkg::CMD_ARM || c == dtt_pkg::CMD_REPERIOD) used_period[p] = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent++;
  endtask

  task automatic gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // waits for every expected transaction, then lets the block settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic set_window(logic [31:0] w);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= w;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // a period never stored anywhere, so a keep-start re-period always changes it
  function automatic logic [31:0] fresh_period();
    logic [31:0] v;
    do v = ($urandom_range(0, 1) != 0) ? 32'($urandom_range(1, 400)) : $urandom;
    while (used_period.exists(v));
    return v;
  endfunction

  task automatic random_item();
    int pick;
    int tj;
    logic [2:0] c;
    logic [31:0] p;
    logic fn;
    // advance time, with occasional jumps back, far ahead and near wrap
    tj = $urandom_range(0, 99);
    if (tj < 80) clock_ms += 64'($urandom_range(0, 60));
    else if (tj < 86) clock_ms -= 64'($urandom_range(0, 5000));
    else if (tj < 91) clock_ms -= {32'd0, $urandom} + 64'($urandom_range(0, 3));
    else if (tj < 95) clock_ms += 64'd4000000;
    else if (tj < 98) clock_ms = 64'hFFFF_FFFF_FFFF_FF00 + 64'($urandom_range(0, 200));
    else clock_ms = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 30) c = dtt_pkg::CMD_ARM;
    else if (pick < 40) c = dtt_pkg::CMD_CANCEL;
    else if (pick < 50) c = dtt_pkg::CMD_REFRESH;
    else if (pick < 62) c = dtt_pkg::CMD_REPERIOD;
    else if (pick < 85) c = dtt_pkg::CMD_EXPIRE;
    else if (pick < 96) c = dtt_pkg::CMD_QUERY;
    else c = pick[0] ? CMD_UNUSED_7 : CMD_UNUSED_6;
    p = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 120));
    fn = 1'($urandom_range(0, 1));
    if (c == dtt_pkg::CMD_REPERIOD && !fn) p = fresh_period();
    send(c, 4'($urandom_range(0, 15)), p, 1'($urandom_range(0, 1)), fn, clock_ms);
    gap();
  endtask

  initial begin
    used_period[32'd0] = 1'b1;  // slots never written read a zero period
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table behavior
    send(dtt_pkg::CMD_QUERY, 0, 0, 0, 0, 64'd0);
    send(dtt_pkg::CMD_EXPIRE, 0, 0, 0, 0, 64'd5);
    send(dtt_pkg::CMD_CANCEL, 4'd15, 0, 0, 0, 64'd5);
    send(dtt_pkg::CMD_REPERIOD, 4'd3, 32'd77, 0, 0, 64'd5);
    send(CMD_UNUSED_6, 0, 0, 0, 0, 64'd5);
    send(CMD_UNUSED_7, 4'hf, 32'hFFFF_FFFF, 1, 1, '1);
    // fill the table, extreme periods and a wrapping deadline
    send(dtt_pkg::CMD_ARM, 0, 32'd10, 1, 0, 64'd100);
    send(dtt_pkg::CMD_ARM, 0, 32'hFFFF_FFFF, 0, 0, 64'hFFFF_FFFF_FFFF_FFF0);
    send(dtt_pkg::CMD_ARM, 0, 32'd0, 0, 0, 64'd100);
    for (int i = 0; i < 14; i++) send(dtt_pkg::CMD_ARM, 0, 32'(i * 3), i[0], 0, 64'd100);
    send(dtt_pkg::CMD_QUERY, 0, 0, 0, 0, 64'd50);
    send(dtt_pkg::CMD_REFRESH, 4'd0, 0, 0, 0, 64'd200);
    send(dtt_pkg::CMD_REPERIOD, 4'd1, 32'd5, 0, 1, 64'd120);
    send(dtt_pkg::CMD_REPERIOD, 4'd0, fresh_period(), 0, 0, 64'd130);
    send(dtt_pkg::CMD_EXPIRE, 0, 0, 0, 0, 64'd150);
    // backward jump while prev minus the window wraps below zero: everything fires
    send(dtt_pkg::CMD_EXPIRE, 0, 0, 0, 0, 64'd0);
    set_window(32'd0);
    send(dtt_pkg::CMD_EXPIRE, 0, 0, 0, 0, 64'd149);
    send(dtt_pkg::CMD_QUERY, 0, 0, 0, 0, '1);

    // random phases over several window settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_window(32'hFFFF_FFFF);
        1: set_window(32'd3600000);
        2: set_window($urandom);
        default: set_window(32'd0);
      endcase
      for (int i = 0; i < 65; i++) begin
        random_item();
        if (ph == 1 && i == 40) drain();
      end
    end
    calm = 1'b1;
    for (int i = 0; i < 25; i++) random_item();

    drain();
    $display("ran %0d commands over four window settings, with wraps, rollbacks and full table",
             sent);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
